// ===== hw/rtl/clcd_pkg.sv =====
package clcd_pkg;

  // Operation codes carried by the input operation field.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_INIT   = 3'd1;
  localparam logic [2:0] OP_CMD    = 3'd2;
  localparam logic [2:0] OP_CHAR   = 3'd3;
  localparam logic [2:0] OP_NIBBLE = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_POWERUP_WAIT   = 3'd0;
  localparam logic [2:0] REG_WAKE_WAIT      = 3'd1;
  localparam logic [2:0] REG_MODE_WAIT      = 3'd2;
  localparam logic [2:0] REG_STEP_WAIT      = 3'd3;
  localparam logic [2:0] REG_SEL_REL_WAIT   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] POWERUP_WAIT_RST = 16'd40000;
  localparam logic [9:0]  WAKE_WAIT_RST    = 10'd200;
  localparam logic [9:0]  MODE_WAIT_RST    = 10'd40;
  localparam logic [9:0]  STEP_WAIT_RST    = 10'd100;
  localparam logic [9:0]  SEL_REL_WAIT_RST = 10'd50;

  localparam int unsigned CLCD_QUEUE_DEPTH = 2;

  // Command bytes sent at the end of the init sequence.
  localparam logic [7:0] INIT_CMDS [4] = '{8'h28, 8'h10, 8'h0F, 8'h06};

  // Wake and mode nibbles.
  localparam logic [3:0] WAKE_NIBBLE = 4'h3;
  localparam logic [3:0] MODE_NIBBLE = 4'h2;

  typedef enum logic [2:0] {
    KIND_IGNORE,
    KIND_TICK,
    KIND_INIT,
    KIND_CMD,
    KIND_CHAR,
    KIND_NIBBLE
  } kind_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] byte_value;
  } clcd_in_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       enable_line;
    logic       register_select;
    logic       busy_res;
    logic       rejected;
  } clcd_out_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
  } qitem_t;

  typedef struct packed {
    logic [15:0] powerup_wait;
    logic [9:0]  wake_wait;
    logic [9:0]  mode_wait;
    logic [9:0]  step_wait;
    logic [9:0]  sel_rel_wait;
  } cfg_t;

endpackage

// ===== hw/rtl/clcd_front.sv =====
module clcd_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  clcd_pkg::clcd_in_t in_req_i,
  input  logic               q_full_i,
  output logic               push_o,
  output clcd_pkg::qitem_t   push_item_o
);
  import clcd_pkg::*;

  kind_e kind;

  // Sort the incoming operation into the kind the back end acts on.
  always_comb begin
    unique case (in_req_i.operation)
      OP_TICK:   kind = KIND_TICK;
      OP_INIT:   kind = KIND_INIT;
      OP_CMD:    kind = KIND_CMD;
      OP_CHAR:   kind = KIND_CHAR;
      OP_NIBBLE: kind = KIND_NIBBLE;
      default:   kind = KIND_IGNORE;
    endcase
  end

  assign in_stall_o             = q_full_i;
  assign push_o                 = in_valid_i && !q_full_i;
  assign push_item_o.kind       = kind;
  assign push_item_o.byte_value = in_req_i.byte_value;

endmodule

// ===== hw/rtl/clcd_queue.sv =====
module clcd_queue #(
  parameter int unsigned Depth = clcd_pkg::CLCD_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clcd_pkg::qitem_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output clcd_pkg::qitem_t head_o
);
  import clcd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qitem_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/clcd_back.sv =====
module clcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                q_valid_i,
  input  clcd_pkg::qitem_t    q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clcd_pkg::clcd_out_t out_res_o
);
  import clcd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_POWERUP,
    PH_RS_SETUP,
    PH_HI_SET,
    PH_HI_EN_H,
    PH_HI_EN_L,
    PH_LO_SET,
    PH_LO_EN_H,
    PH_LO_EN_L,
    PH_RS_RELEASE,
    PH_GAP,
    PH_SN_SET,
    PH_SN_EN_H,
    PH_SN_EN_L
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] wait_left;
    logic [7:0]  held_byte;
    logic [3:0]  init_step;
    logic [3:0]  nibble;
    logic        en_level;
    logic        rs_level;
  } seq_t;

  cfg_t      cfg_q;
  seq_t      seq_q, seq_d;
  clcd_out_t res_q, res_d;
  logic      out_valid_q, out_valid_d;
  logic      busy;
  logic      rej;

  // Begin the init item selected by init_step; past the last one, go idle.
  function automatic seq_t start_item(seq_t s, cfg_t c);
    seq_t r;
    r = s;
    if (s.init_step >= 4'd1 && s.init_step <= 4'd3) begin
      r.nibble    = WAKE_NIBBLE;
      r.phase     = PH_SN_SET;
      r.wait_left = {6'd0, c.step_wait};
    end else if (s.init_step == 4'd4) begin
      r.nibble    = MODE_NIBBLE;
      r.phase     = PH_SN_SET;
      r.wait_left = {6'd0, c.step_wait};
    end else if (s.init_step >= 4'd5 && s.init_step <= 4'd8) begin
      r.held_byte = INIT_CMDS[2'(s.init_step - 4'd5)];
      r.nibble    = r.held_byte[7:4];
      r.phase     = PH_HI_SET;
      r.wait_left = {6'd0, c.step_wait};
    end else begin
      r.init_step = 4'd0;
      r.phase     = PH_IDLE;
      r.wait_left = 16'd0;
    end
    return r;
  endfunction

  // Take the next action once the current wait has run out.
  function automatic seq_t advance(seq_t s, cfg_t c);
    seq_t        r;
    logic [15:0] step;
    r    = s;
    step = {6'd0, c.step_wait};
    unique case (s.phase)
      PH_POWERUP: begin
        r.init_step = 4'd1;
        r = start_item(r, c);
      end
      PH_RS_SETUP: begin
        r.nibble    = s.held_byte[7:4];
        r.phase     = PH_HI_SET;
        r.wait_left = step;
      end
      PH_HI_SET: begin
        r.en_level  = 1'b1;
        r.phase     = PH_HI_EN_H;
        r.wait_left = step;
      end
      PH_HI_EN_H: begin
        r.en_level  = 1'b0;
        r.phase     = PH_HI_EN_L;
        r.wait_left = step;
      end
      PH_HI_EN_L: begin
        r.nibble    = s.held_byte[3:0];
        r.phase     = PH_LO_SET;
        r.wait_left = step;
      end
      PH_LO_SET: begin
        r.en_level  = 1'b1;
        r.phase     = PH_LO_EN_H;
        r.wait_left = step;
      end
      PH_LO_EN_H: begin
        r.en_level  = 1'b0;
        r.phase     = PH_LO_EN_L;
        r.wait_left = step;
      end
      PH_LO_EN_L: begin
        if (s.rs_level) begin
          r.rs_level  = 1'b0;
          r.phase     = PH_RS_RELEASE;
          r.wait_left = {6'd0, c.sel_rel_wait};
        end else if (s.init_step != 4'd0) begin
          r.init_step = s.init_step + 4'd1;
          r = start_item(r, c);
        end else begin
          r.phase     = PH_IDLE;
          r.wait_left = 16'd0;
        end
      end
      PH_SN_SET: begin
        r.en_level  = 1'b1;
        r.phase     = PH_SN_EN_H;
        r.wait_left = step;
      end
      PH_SN_EN_H: begin
        r.en_level  = 1'b0;
        r.phase     = PH_SN_EN_L;
        r.wait_left = step;
      end
      PH_SN_EN_L: begin
        if (s.init_step >= 4'd1 && s.init_step <= 4'd3) begin
          r.phase     = PH_GAP;
          r.wait_left = {6'd0, c.wake_wait};
        end else if (s.init_step == 4'd4) begin
          r.phase     = PH_GAP;
          r.wait_left = {6'd0, c.mode_wait};
        end else begin
          r.init_step = 4'd0;
          r.phase     = PH_IDLE;
          r.wait_left = 16'd0;
        end
      end
      PH_GAP: begin
        r.init_step = s.init_step + 4'd1;
        r = start_item(r, c);
      end
      default: begin
        // The select release wait ends the character; anything else is idle.
        r.init_step = 4'd0;
        r.phase     = PH_IDLE;
        r.wait_left = 16'd0;
      end
    endcase
    return r;
  endfunction

  assign busy    = (seq_q.phase != PH_IDLE);
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    seq_d = seq_q;
    rej   = 1'b0;
    if (q_pop_o) begin
      case (q_head_i.kind) inside
        KIND_TICK: begin
          if (busy) begin
            if (seq_q.wait_left != 16'd0) begin
              seq_d.wait_left = seq_q.wait_left - 16'd1;
            end
            if (seq_d.wait_left == 16'd0) begin
              seq_d = advance(seq_d, cfg_q);
            end
          end
        end
        KIND_INIT, KIND_CMD, KIND_CHAR, KIND_NIBBLE: begin
          if (busy) begin
            rej = 1'b1;
          end else if (q_head_i.kind == KIND_INIT) begin
            seq_d.nibble    = 4'd0;
            seq_d.en_level  = 1'b0;
            seq_d.rs_level  = 1'b0;
            seq_d.init_step = 4'd0;
            seq_d.phase     = PH_POWERUP;
            seq_d.wait_left = cfg_q.powerup_wait;
          end else if (q_head_i.kind == KIND_CHAR) begin
            seq_d.held_byte = q_head_i.byte_value;
            seq_d.rs_level  = 1'b1;
            seq_d.phase     = PH_RS_SETUP;
            seq_d.wait_left = {6'd0, cfg_q.step_wait};
          end else begin
            seq_d.held_byte = q_head_i.byte_value;
            seq_d.nibble    = q_head_i.byte_value[7:4];
            seq_d.phase     = (q_head_i.kind == KIND_CMD) ? PH_HI_SET : PH_SN_SET;
            seq_d.wait_left = {6'd0, cfg_q.step_wait};
          end
        end
        default: begin
          // Unknown operations leave everything as it is.
        end
      endcase
    end

    res_d.data_nibble     = seq_d.nibble;
    res_d.enable_line     = seq_d.en_level;
    res_d.register_select = seq_d.rs_level;
    res_d.busy_res        = (seq_d.phase != PH_IDLE);
    res_d.rejected        = rej;

    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '{phase: PH_IDLE, default: '0};
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        res_q <= res_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.powerup_wait <= POWERUP_WAIT_RST;
      cfg_q.wake_wait    <= WAKE_WAIT_RST;
      cfg_q.mode_wait    <= MODE_WAIT_RST;
      cfg_q.step_wait    <= STEP_WAIT_RST;
      cfg_q.sel_rel_wait <= SEL_REL_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POWERUP_WAIT: cfg_q.powerup_wait <= cfg_data_i;
        REG_WAKE_WAIT:    cfg_q.wake_wait    <= cfg_data_i[9:0];
        REG_MODE_WAIT:    cfg_q.mode_wait    <= cfg_data_i[9:0];
        REG_STEP_WAIT:    cfg_q.step_wait    <= cfg_data_i[9:0];
        REG_SEL_REL_WAIT: cfg_q.sel_rel_wait <= cfg_data_i[9:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== hw/rtl/char_lcd_4bit_sequencer.sv =====
// Character LCD sequencer for a 4-bit bus with enable and register-select lines.
// Each input request is a one-microsecond tick or an order: run the init
// sequence, send a command byte, send a character, or send a high nibble only.
// Every request yields exactly one result: the line levels after it, a busy
// flag and a flag that tells whether an order arrived while busy and was dropped.
// Channels use valid and stall; a request moves at an edge with valid high and
// stall low. The front end decodes each request into a two-entry queue; the back
// end takes one queued request per cycle while the receiver does not stall,
// updates the sequencer and loads the output register. A taken request is
// registered in the queue and then in the output register; the sustained rate
// is one request per clock cycle. When the receiver stalls, the result register
// holds, the back end stops, the queue fills and in_stall_o rises once it is
// full. Reset sets the timing registers to their defaults, returns the
// sequencer to idle with all lines low and empties the queue. Timing registers
// are written through cfg_we_i, cfg_index_i and cfg_data_i; the user must write
// them only while no work is in flight, as the block does not enforce it.
module char_lcd_4bit_sequencer #(
  parameter int unsigned QueueDepth = clcd_pkg::CLCD_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clcd_pkg::clcd_in_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clcd_pkg::clcd_out_t out_res_o
);
  import clcd_pkg::*;

  logic   q_full;
  logic   q_push;
  qitem_t q_push_item;
  logic   q_pop;
  logic   q_valid;
  qitem_t q_head;

  // The front end only decodes; it pushes a valid request whenever the queue has room.
  clcd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_item_o (q_push_item)
  );

  // The queue lets the two sides stall independently of each other.
  clcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // The back end runs the timed sequence and owns the result register.
  clcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

`ifndef SYNTH
  // A dropped request can only happen while a sequence is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.rejected |-> out_res_o.busy_res)
    else $error("rejected result while not busy");

  // Enable is only ever raised inside a running sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.enable_line |-> out_res_o.busy_res)
    else $error("enable high while idle");

  // Register select is only ever raised inside a running sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.register_select |-> out_res_o.busy_res)
    else $error("register select high while idle");

  // An accepted request is in the queue at the following edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_valid)
    else $error("accepted request missing from queue");
`endif

endmodule
